@@ rtl/d2d_pkg.sv @@
// ----------------------------------------------------------------------------
// d2d_pkg
// Shared types, constants and helpers for the disparity to depth pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package d2d_pkg;

  // configuration register indexes
  localparam logic [1:0] REG_FOCAL_RATIO = 2'd0;
  localparam logic [1:0] REG_REF_DIST    = 2'd1;
  localparam logic [1:0] REG_IMG_WIDTH   = 2'd2;
  localparam logic [1:0] REG_IMG_HEIGHT  = 2'd3;

  // configuration reset values
  localparam logic [23:0] FOCAL_RATIO_RST = 24'd10837333;
  localparam logic [15:0] REF_DIST_RST    = 16'd600;
  localparam logic [12:0] IMG_WIDTH_RST   = 13'd640;
  localparam logic [12:0] IMG_HEIGHT_RST  = 13'd480;

  // raw sample offset (64 pixels in sixteenths)
  localparam logic signed [12:0] SAMPLE_OFFSET = 13'sd1024;

  // depth quotient carries five fraction bits
  localparam int QUO_FRAC = 5;
  localparam int QUO_W    = 22;

  // projection: coordinate = 6 * mag * fine / 2540, rounded
  localparam logic [11:0] PROJ_DIV   = 12'd2540;
  localparam logic [12:0] PROJ_DIV2  = 13'd5080;
  localparam logic [34:0] PROJ_BIAS  = 35'd1270;
  localparam int          PROJ_QUO_W = 24;
  // floor(2^35 / 2540), applied to the upper 24 numerator bits
  localparam logic [23:0] PROJ_RECIP = 24'd13527456;

  localparam logic [15:0] DEPTH_MM_MAX   = 16'hFFFF;
  localparam logic [19:0] DEPTH_FINE_MAX = 20'hFFFFF;
  localparam logic [23:0] POINT_NEG_MAG  = 24'd4194304;
  localparam logic [23:0] POINT_POS_MAX  = 24'd4194303;

  // side data carried through the depth divider
  typedef struct packed {
    logic        zero;
    logic        bad;
    logic        ovf;
    logic [11:0] col;
    logic [11:0] row;
    logic [11:0] cx;
    logic [11:0] cy;
  } dsd_t;

  // side data carried through the projection stages
  typedef struct packed {
    logic [15:0] mm;
    logic [19:0] fine;
    logic        bad;
    logic        neg_x;
  } psd_t;

  // signed saturation of a projected magnitude
  function automatic logic [22:0] pt_sat(input logic neg, input logic [23:0] q);
    logic [23:0] m;
    begin
      if (neg) begin
        m = (q > POINT_NEG_MAG) ? POINT_NEG_MAG : q;
        pt_sat = 23'(24'd0 - m);
      end else begin
        m = (q > POINT_POS_MAX) ? POINT_POS_MAX : q;
        pt_sat = m[22:0];
      end
    end
  endfunction

endpackage

`default_nettype wire

@@ rtl/d2d_div.sv @@
// ----------------------------------------------------------------------------
// d2d_div
// Pipelined restoring divider, one quotient bit per register stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module d2d_div #(
  parameter int NW = 45,
  parameter int DW = 32,
  parameter int QW = 22,
  parameter int PW = 1
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  wire logic          in_valid,
  input  wire logic [NW-1:0] in_num,
  input  wire logic [DW-1:0] in_den,
  input  wire logic [PW-1:0] in_side,
  output logic               out_valid,
  output logic [QW-1:0]      out_quo,
  output logic [PW-1:0]      out_side
);

  localparam int XW = ((NW > DW + QW) ? NW : DW + QW) + 1;

  logic [NW-1:0] rem_r  [0:QW-1];
  logic [DW-1:0] den_r  [0:QW-1];
  logic [QW-1:0] quo_r  [0:QW-1];
  logic [PW-1:0] side_r [0:QW-1];
  logic          vld_r  [0:QW-1];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [NW-1:0] r_src;
    logic [DW-1:0] d_src;
    logic [QW-1:0] q_src;
    logic [PW-1:0] s_src;
    logic          v_src;
    logic [XW-1:0] sh;
    logic [XW-1:0] rx;
    logic [XW-1:0] diff;
    logic          ge;

    // stage source: module input or previous stage
    if (k == 0) begin : g_first
      assign r_src = in_num;
      assign d_src = in_den;
      assign q_src = '0;
      assign s_src = in_side;
      assign v_src = in_valid;
    end else begin : g_next
      assign r_src = rem_r[k-1];
      assign d_src = den_r[k-1];
      assign q_src = quo_r[k-1];
      assign s_src = side_r[k-1];
      assign v_src = vld_r[k-1];
    end

    // trial subtract of the shifted divisor
    assign sh   = XW'(d_src) << (QW - 1 - k);
    assign rx   = XW'(r_src);
    assign diff = rx - sh;
    assign ge   = (rx >= sh);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= v_src;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= ge ? diff[NW-1:0] : r_src;
        den_r[k]  <= d_src;
        quo_r[k]  <= q_src | (QW'(ge) << (QW - 1 - k));
        side_r[k] <= s_src;
      end
    end
  end

  assign out_valid = vld_r[QW-1];
  assign out_quo   = quo_r[QW-1];
  assign out_side  = side_r[QW-1];

endmodule

`default_nettype wire

@@ rtl/d2d_front.sv @@
// ----------------------------------------------------------------------------
// d2d_front
// Numerator and denominator of the triangulation, sign and range checks.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module d2d_front
  import d2d_pkg::*;
#(
  parameter int MAX_DIM = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        en,
  input  wire logic        in_valid,
  input  wire logic [11:0] sample,
  input  wire logic [11:0] column,
  input  wire logic [11:0] row,
  input  wire logic [23:0] focal_ratio,
  input  wire logic [15:0] ref_dist,
  input  wire logic [12:0] img_width,
  input  wire logic [12:0] img_height,
  output logic             out_valid,
  output logic [44:0]      out_num,
  output logic [31:0]      out_den,
  output dsd_t             out_side
);

  logic signed [12:0] s_c;
  logic signed [29:0] sd_c;
  logic [31:0]        wcl_c;
  logic [31:0]        hcl_c;
  dsd_t               side1_c;
  dsd_t               side3_c;

  // stage 1 registers
  logic               v1_r;
  logic [39:0]        num1_r;
  logic signed [29:0] sd1_r;
  logic [23:0]        f1_r;
  dsd_t               side1_r;
  // stage 2 registers
  logic               v2_r;
  logic [39:0]        num2_r;
  logic signed [34:0] den2_r;
  dsd_t               side2_r;
  // stage 3 registers
  logic               v3_r;
  logic [44:0]        num3_r;
  logic [31:0]        den3_r;
  dsd_t               side3_r;

  logic bad_c;
  logic ovf_c;

  // offset disparity times reference distance
  assign s_c  = $signed({1'b0, sample}) - SAMPLE_OFFSET;
  assign sd_c = 30'(s_c) * 30'($signed({1'b0, ref_dist}));

  // frame centres from clamped sizes
  assign wcl_c = (32'(img_width) > 32'(MAX_DIM)) ? 32'(MAX_DIM) : 32'(img_width);
  assign hcl_c = (32'(img_height) > 32'(MAX_DIM)) ? 32'(MAX_DIM) : 32'(img_height);

  // denominator sign and quotient range
  assign bad_c = !side2_r.zero && (den2_r[34] || (den2_r == '0));
  assign ovf_c = 49'(num2_r) >= {den2_r[31:0], 17'd0};

  // side data entering and leaving the checks
  always_comb begin
    side1_c      = '0;
    side1_c.zero = (sample == '0);
    side1_c.col  = column;
    side1_c.row  = row;
    side1_c.cx   = wcl_c[12:1];
    side1_c.cy   = hcl_c[12:1];
    side3_c      = side2_r;
    side3_c.bad  = bad_c;
    side3_c.ovf  = ovf_c;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // stage 1: products
      num1_r  <= 40'(focal_ratio) * 40'(ref_dist);
      sd1_r   <= sd_c;
      f1_r    <= focal_ratio;
      side1_r <= side1_c;
      // stage 2: denominator
      num2_r  <= num1_r;
      den2_r  <= $signed(35'(f1_r)) + (35'(sd1_r) <<< 4);
      side2_r <= side1_r;
      // stage 3: checks and divider operands
      num3_r  <= {num2_r, 5'd0};
      den3_r  <= bad_c ? 32'd1 : den2_r[31:0];
      side3_r <= side3_c;
    end
  end

  assign out_valid = v3_r;
  assign out_num   = num3_r;
  assign out_den   = den3_r;
  assign out_side  = side3_r;

endmodule

`default_nettype wire

@@ rtl/d2d_scale.sv @@
// ----------------------------------------------------------------------------
// d2d_scale
// Rounds and saturates depth, projects it onto the point coordinates.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module d2d_scale
  import d2d_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   en,
  input  wire logic                   in_valid,
  input  wire logic [QUO_W-1:0]       in_quo,
  input  wire dsd_t                   in_side,
  output logic                        out_valid,
  output logic [PROJ_QUO_W-1:0]       out_qx,
  output logic [PROJ_QUO_W-1:0]       out_qy,
  output psd_t                        out_side,
  output logic                        out_neg_y
);

  logic [22:0] qa_c;
  logic [22:0] qf_c;
  logic [17:0] mmw_c;
  logic [21:0] fw_c;
  logic        kill_c;
  logic [15:0] mm_c;
  logic [19:0] fine_c;
  logic        negx_c;
  logic        negy_c;
  psd_t        side4_c;
  logic [34:0] rxw_c, ryw_c;

  logic        v4_r, v5_r, v6_r, v7_r, v8_r, v9_r;
  psd_t        side4_r, side5_r, side6_r, side7_r, side8_r, side9_r;
  logic [11:0] magx4_r, magy4_r;
  logic        negy4_r, negy5_r, negy6_r, negy7_r, negy8_r, negy9_r;
  logic [31:0] px5_r, py5_r;
  logic [34:0] nx6_r, ny6_r;
  logic [34:0] nx7_r, ny7_r;
  logic [47:0] ex7_r, ey7_r;
  logic [23:0] qx8_r, qy8_r;
  logic [12:0] rx8_r, ry8_r;
  logic [23:0] qx9_r, qy9_r;

  // round the Q.5 quotient to whole and Q.4 millimetres
  assign qa_c   = 23'(in_quo) + 23'd16;
  assign qf_c   = 23'(in_quo) + 23'd1;
  assign mmw_c  = qa_c[22:5];
  assign fw_c   = qf_c[22:1];
  assign kill_c = in_side.zero || in_side.bad;

  always_comb begin
    if (kill_c) begin
      mm_c   = '0;
      fine_c = '0;
    end else begin
      mm_c   = (in_side.ovf || (mmw_c > 18'(DEPTH_MM_MAX))) ? DEPTH_MM_MAX : mmw_c[15:0];
      fine_c = (in_side.ovf || (fw_c > 22'(DEPTH_FINE_MAX))) ? DEPTH_FINE_MAX : fw_c[19:0];
    end
  end

  assign negx_c = in_side.col > in_side.cx;
  assign negy_c = in_side.row > in_side.cy;

  // side data for the projection stages
  always_comb begin
    side4_c.mm    = mm_c;
    side4_c.fine  = fine_c;
    side4_c.bad   = in_side.bad && !in_side.zero;
    side4_c.neg_x = negx_c;
  end

  // remainder left by the reciprocal estimate, below three divisors
  assign rxw_c = nx7_r - 35'(ex7_r[47:24]) * 35'(PROJ_DIV);
  assign ryw_c = ny7_r - 35'(ey7_r[47:24]) * 35'(PROJ_DIV);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
      v8_r <= 1'b0;
      v9_r <= 1'b0;
    end else if (en) begin
      v4_r <= in_valid;
      v5_r <= v4_r;
      v6_r <= v5_r;
      v7_r <= v6_r;
      v8_r <= v7_r;
      v9_r <= v8_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // stage 4: depth and offset magnitudes
      side4_r <= side4_c;
      negy4_r <= negy_c;
      magx4_r <= negx_c ? in_side.col - in_side.cx : in_side.cx - in_side.col;
      magy4_r <= negy_c ? in_side.row - in_side.cy : in_side.cy - in_side.row;
      // stage 5: magnitude times depth
      px5_r   <= 32'(magx4_r) * 32'(side4_r.fine);
      py5_r   <= 32'(magy4_r) * 32'(side4_r.fine);
      side5_r <= side4_r;
      negy5_r <= negy4_r;
      // stage 6: times six plus half divisor
      nx6_r   <= (35'(px5_r) << 2) + (35'(px5_r) << 1) + PROJ_BIAS;
      ny6_r   <= (35'(py5_r) << 2) + (35'(py5_r) << 1) + PROJ_BIAS;
      side6_r <= side5_r;
      negy6_r <= negy5_r;
      // stage 7: reciprocal product of the upper numerator bits
      ex7_r   <= 48'(nx6_r[34:11]) * 48'(PROJ_RECIP);
      ey7_r   <= 48'(ny6_r[34:11]) * 48'(PROJ_RECIP);
      nx7_r   <= nx6_r;
      ny7_r   <= ny6_r;
      side7_r <= side6_r;
      negy7_r <= negy6_r;
      // stage 8: quotient estimate and its remainder
      qx8_r   <= ex7_r[47:24];
      qy8_r   <= ey7_r[47:24];
      rx8_r   <= rxw_c[12:0];
      ry8_r   <= ryw_c[12:0];
      side8_r <= side7_r;
      negy8_r <= negy7_r;
      // stage 9: estimate corrected by up to two
      qx9_r   <= qx8_r + 24'(rx8_r >= 13'(PROJ_DIV)) + 24'(rx8_r >= PROJ_DIV2);
      qy9_r   <= qy8_r + 24'(ry8_r >= 13'(PROJ_DIV)) + 24'(ry8_r >= PROJ_DIV2);
      side9_r <= side8_r;
      negy9_r <= negy8_r;
    end
  end

  assign out_valid = v9_r;
  assign out_qx    = qx9_r;
  assign out_qy    = qy9_r;
  assign out_side  = side9_r;
  assign out_neg_y = negy9_r;

endmodule

`default_nettype wire

@@ rtl/disparity_to_depth_point.sv @@
// Results pass the front stages, depth divider, scale stages and output register.
// Throughput: one transaction per cycle unless the result is stalled; the
// 22-bit depth divider resolves one quotient bit per stage, the projections
// use a reciprocal multiply. A stalled result holds the whole pipeline; input
// is taken whenever the output register is free or being drained.
// Reset (rst_n low, synchronous) clears valid bits and loads register defaults.
// ----------------------------------------------------------------------------
// disparity_to_depth_point
// Disparity to depth triangulation with point cloud projection.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module disparity_to_depth_point
  import d2d_pkg::*;
#(
  parameter int MAX_DIM = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // sample[11:0], column[23:12], row[35:24]
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [87:0]      out_tdata,  // depth_mm[15:0], depth_fine[35:16],
                                       // point_x[58:36], point_y[81:59]
  output logic             out_tuser,  // invalid[0]
  // configuration
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_addr,
  input  wire logic [23:0] cfg_data
);

  logic [23:0] focal_r;
  logic [15:0] dist_r;
  logic [12:0] width_r;
  logic [12:0] height_r;

  logic        en;
  logic        fv;
  logic [44:0] fnum;
  logic [31:0] fden;
  dsd_t        fside;
  logic        dv;
  logic [QUO_W-1:0] dquo;
  dsd_t        dside;
  logic        sv;
  logic [PROJ_QUO_W-1:0] sqx, sqy;
  psd_t        sside;
  logic        sneg_y;

  logic        out_valid_r;
  logic [15:0] mm_r;
  logic [19:0] fine_r;
  logic [22:0] px_r, py_r;
  logic        bad_r;

  // pipeline advance
  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      focal_r  <= FOCAL_RATIO_RST;
      dist_r   <= REF_DIST_RST;
      width_r  <= IMG_WIDTH_RST;
      height_r <= IMG_HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_FOCAL_RATIO: focal_r  <= cfg_data;
        REG_REF_DIST:    dist_r   <= cfg_data[15:0];
        REG_IMG_WIDTH:   width_r  <= cfg_data[12:0];
        REG_IMG_HEIGHT:  height_r <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  d2d_front #(.MAX_DIM(MAX_DIM)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .in_valid    (in_tvalid),
    .sample      (in_tdata[11:0]),
    .column      (in_tdata[23:12]),
    .row         (in_tdata[35:24]),
    .focal_ratio (focal_r),
    .ref_dist    (dist_r),
    .img_width   (width_r),
    .img_height  (height_r),
    .out_valid   (fv),
    .out_num     (fnum),
    .out_den     (fden),
    .out_side    (fside)
  );

  d2d_div #(.NW(45), .DW(32), .QW(QUO_W), .PW($bits(dsd_t))) u_div_depth (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (fv),
    .in_num    (fnum),
    .in_den    (fden),
    .in_side   (fside),
    .out_valid (dv),
    .out_quo   (dquo),
    .out_side  (dside)
  );

  d2d_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (dv),
    .in_quo    (dquo),
    .in_side   (dside),
    .out_valid (sv),
    .out_qx    (sqx),
    .out_qy    (sqy),
    .out_side  (sside),
    .out_neg_y (sneg_y)
  );

  // output register with coordinate saturation
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= sv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mm_r   <= sside.mm;
      fine_r <= sside.fine;
      bad_r  <= sside.bad;
      px_r   <= pt_sat(sside.neg_x, sqx);
      py_r   <= pt_sat(sneg_y, sqy);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, py_r, px_r, fine_r, mm_r};
  assign out_tuser  = bad_r;

  // a stalled result holds still
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // an invalid result carries zero depth
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[35:0] == 36'd0)
    else $error("invalid result with nonzero depth");

  // zero depth projects to the origin
  a_zero_point: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[35:16] == 20'd0 |-> out_tdata[81:36] == 46'd0)
    else $error("zero depth with nonzero point");

endmodule

`default_nettype wire

@@ test/tb_disparity_to_depth_point.sv @@
// ----------------------------------------------------------------------------
// tb_disparity_to_depth_point
// Drives disparity samples with pixel indexes through the depth pipeline under
// several register settings, predicts depth, fine depth, point coordinates and
// the invalid flag per transaction, and compares every result in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_disparity_to_depth_point;
  import d2d_pkg::*;

  typedef struct {
    logic [15:0] mm;
    logic [19:0] fine;
    logic [22:0] px;
    logic [22:0] py;
    logic        bad;
  } depth_res_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [87:0] out_tdata;
  logic        out_tuser;
  logic        cfg_we;
  logic [1:0]  cfg_addr;
  logic [23:0] cfg_data;

  // shadow of the configuration registers
  logic [23:0] focal_q;
  logic [15:0] dist_q;
  logic [12:0] width_q;
  logic [12:0] height_q;

  depth_res_t depth_queue[$];
  int         n_fail;
  int         n_sent;
  int         n_checked;
  int         n_bad;
  longint     cycles;
  int         hold_off;
  int         burst_left;
  bit         gap_en;

  disparity_to_depth_point dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // coordinate of one axis in signed q.4 mm
  function automatic logic [22:0] axis_point(logic [12:0] size, logic [11:0] idx,
                                             logic [19:0] fine);
    logic [63:0] s;
    logic [63:0] c;
    logic [63:0] m;
    logic [63:0] q;
    logic        neg;
    s = (size > 13'd4096) ? 64'd4096 : 64'(size);
    c = s >> 1;
    neg = 64'(idx) > c;
    m = neg ? 64'(idx) - c : c - 64'(idx);
    q = (6 * m * 64'(fine) + 1270) / 2540;
    if (neg) begin
      if (q > 64'd4194304) q = 64'd4194304;
      return 23'(64'd0 - q);
    end
    if (q > 64'd4194303) q = 64'd4194303;
    return q[22:0];
  endfunction

  function automatic depth_res_t triangulate(logic [11:0] sample, logic [11:0] col,
                                            logic [11:0] row);
    depth_res_t r;
    longint     den;
    logic [63:0] num;
    logic [63:0] q;
    r = '{default: '0};
    if (sample != 0) begin
      den = longint'(focal_q) + 16 * (longint'(sample) - 1024) * longint'(dist_q);
      if (den <= 0) begin
        r.bad = 1'b1;
      end else begin
        num = 64'(focal_q) * 64'(dist_q);
        q = (2 * num + den) / (2 * den);
        r.mm = (q > 65535) ? 16'hFFFF : q[15:0];
        q = (32 * num + den) / (2 * den);
        r.fine = (q > 1048575) ? 20'hFFFFF : q[19:0];
        r.px = axis_point(width_q, col, r.fine);
        r.py = axis_point(height_q, row, r.fine);
      end
    end
    return r;
  endfunction

  // one input transaction, bursts separated by random gaps
  task automatic send_pixel(logic [11:0] sample, logic [11:0] col, logic [11:0] row);
    int gap;
    gap = 0;
    if (gap_en && burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = $urandom_range(0, 6);
    end
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    if (burst_left > 0) burst_left--;
    in_tvalid <= 1'b1;
    in_tdata <= {4'd0, row, col, sample};
    depth_queue.push_back(triangulate(sample, col, row));
    n_sent++;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic drain;
    in_tvalid <= 1'b0;
    while (depth_queue.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [23:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      REG_FOCAL_RATIO: focal_q = val;
      REG_REF_DIST:    dist_q = val[15:0];
      REG_IMG_WIDTH:   width_q = val[12:0];
      REG_IMG_HEIGHT:  height_q = val[12:0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic [23:0] f, logic [15:0] d, logic [12:0] w,
                            logic [12:0] h);
    drain();
    write_reg(REG_FOCAL_RATIO, f);
    write_reg(REG_REF_DIST, 24'(d));
    write_reg(REG_IMG_WIDTH, 24'(w));
    write_reg(REG_IMG_HEIGHT, 24'(h));
    cfg_we <= 1'b0;
  endtask

  // field extremes, zero sample, bad denominator, saturation, far indexes
  task automatic test_directed;
    send_pixel(12'd0, 12'd0, 12'd0);
    send_pixel(12'd0, 12'hFFF, 12'hFFF);
    send_pixel(12'd1, 12'd5, 12'd5);
    send_pixel(12'd1024, 12'd320, 12'd240);
    send_pixel(12'd1025, 12'd0, 12'd0);
    send_pixel(12'hFFF, 12'hFFF, 12'hFFF);
    send_pixel(12'hFFF, 12'd0, 12'd0);
    send_pixel(12'd1200, 12'd639, 12'd479);
    send_pixel(12'd900, 12'd100, 12'd400);
    send_pixel(12'd300, 12'hAAA, 12'h555);
    send_pixel(12'd1023, 12'h555, 12'hAAA);
  endtask

  // random pixels around the disparity offset plus full range
  task automatic test_random(int n);
    logic [11:0] s;
    repeat (n) begin
      case ($urandom_range(0, 3))
        0:       s = 12'($urandom_range(0, 4095));
        1:       s = 12'($urandom_range(1000, 1100));
        2:       s = 12'($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1024, 4095));
        default: s = 12'($urandom_range(1, 1023));
      endcase
      send_pixel(s, 12'($urandom), 12'($urandom));
    end
  endtask

  // receiver holds off so the pipeline fills and stalls input
  task automatic test_backpressure;
    hold_off = 300;
    gap_en = 1'b0;
    test_random(150);
    gap_en = 1'b1;
    drain();
  endtask

  // receiver stall pattern and long hold-off counter
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= (cycles % 512 < 128) ? 1'b1 : ($urandom_range(0, 3) != 0);
    end
  end

  // result checker
  always @(posedge clk) begin
    depth_res_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (depth_queue.size() == 0) begin
        $error("unexpected result transaction");
        n_fail++;
      end else begin
        e = depth_queue.pop_front();
        n_checked++;
        if (e.bad) n_bad++;
        if (out_tdata[15:0] !== e.mm) begin
          $error("depth_mm exp %0d got %0d", e.mm, out_tdata[15:0]);
          n_fail++;
        end
        if (out_tdata[35:16] !== e.fine) begin
          $error("depth_fine exp %0d got %0d", e.fine, out_tdata[35:16]);
          n_fail++;
        end
        if (out_tdata[58:36] !== e.px) begin
          $error("point_x exp %0d got %0d", $signed(e.px), $signed(out_tdata[58:36]));
          n_fail++;
        end
        if (out_tdata[81:59] !== e.py) begin
          $error("point_y exp %0d got %0d", $signed(e.py), $signed(out_tdata[81:59]));
          n_fail++;
        end
        if (out_tuser !== e.bad) begin
          $error("invalid exp %0d got %0d", e.bad, out_tuser);
          n_fail++;
        end
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_we = 1'b0;
    cfg_addr = REG_FOCAL_RATIO;
    cfg_data = '0;
    cycles = 0;
    hold_off = 0;
    burst_left = 0;
    gap_en = 1'b1;
    n_fail = 0;
    n_sent = 0;
    n_checked = 0;
    n_bad = 0;
    focal_q = FOCAL_RATIO_RST;
    dist_q = REF_DIST_RST;
    width_q = IMG_WIDTH_RST;
    height_q = IMG_HEIGHT_RST;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random(250);
    test_backpressure();
    set_config(24'd256, 16'd1, 13'd1, 13'd1);
    test_directed();
    test_random(200);
    set_config(24'hFFFFFF, 16'hFFFF, 13'd4096, 13'd4096);
    test_directed();
    test_random(250);
    set_config(24'd0, 16'd1000, 13'd0, 13'h1FFF);
    test_directed();
    test_random(200);
    set_config(24'd65536, 16'd2000, 13'd1280, 13'd720);
    test_random(300);
    set_config(24'($urandom_range(256, 24'hFFFFFF)), 16'($urandom_range(1, 65535)),
               13'($urandom_range(1, 4096)), 13'($urandom_range(1, 4096)));
    test_random(250);
    drain();

    $display("covered %0d pixels, %0d checked, %0d with bad denominator, 6 settings",
             n_sent, n_checked, n_bad);
    if (n_fail == 0 && depth_queue.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
